// ===== sv/u8vql_pkg.sv =====
// shared types, byte constants and helpers for the utf-8 validator and quoted length counter
package u8vql_pkg;

  // default counter width and fixed width of the reported length
  localparam int unsigned LENGTH_WIDTH_DEF = 32;
  localparam int unsigned OUT_LEN_W        = 32;

  // ascii bytes that matter for quoting
  localparam logic [7:0] BYTE_QUOTE     = 8'h22;
  localparam logic [7:0] BYTE_BACKSLASH = 8'h5c;

  // lead and continuation byte bounds
  localparam logic [7:0] BYTE_CONT_LO  = 8'h80;
  localparam logic [7:0] BYTE_CONT_HI  = 8'hbf;
  localparam logic [7:0] BYTE_LEAD2_LO = 8'hc2;
  localparam logic [7:0] BYTE_LEAD2_HI = 8'hdf;
  localparam logic [7:0] BYTE_LEAD3_LO = 8'he0;
  localparam logic [7:0] BYTE_LEAD3_HI = 8'hef;
  localparam logic [7:0] BYTE_LEAD3_SR = 8'hed;
  localparam logic [7:0] BYTE_LEAD4_LO = 8'hf0;
  localparam logic [7:0] BYTE_LEAD4_HI = 8'hf4;
  localparam logic [7:0] BYTE_E0_LO    = 8'ha0;
  localparam logic [7:0] BYTE_ED_HI    = 8'h9f;
  localparam logic [7:0] BYTE_F0_LO    = 8'h90;
  localparam logic [7:0] BYTE_F4_HI    = 8'h8f;

  // allowed range of the next continuation byte
  typedef enum logic [2:0] {
    CLS_ANY = 3'd0,  // 80..bf
    CLS_E0  = 3'd1,  // a0..bf
    CLS_ED  = 3'd2,  // 80..9f
    CLS_F0  = 3'd3,  // 90..bf
    CLS_F4  = 3'd4   // 80..8f
  } cls_e;

  // one input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } item_t;

  // one result item
  typedef struct packed {
    logic                 utf8_ok;
    logic [OUT_LEN_W-1:0] quoted_length;
    logic                 length_saturated;
  } result_t;

  // continuation byte range check
  function automatic logic in_class(input cls_e cls, input logic [7:0] b);
    logic ok;
    unique case (cls)
      CLS_E0:  ok = (b >= BYTE_E0_LO)   && (b <= BYTE_CONT_HI);
      CLS_ED:  ok = (b >= BYTE_CONT_LO) && (b <= BYTE_ED_HI);
      CLS_F0:  ok = (b >= BYTE_F0_LO)   && (b <= BYTE_CONT_HI);
      CLS_F4:  ok = (b >= BYTE_CONT_LO) && (b <= BYTE_F4_HI);
      default: ok = (b >= BYTE_CONT_LO) && (b <= BYTE_CONT_HI);
    endcase
    return ok;
  endfunction

endpackage

// ===== sv/u8vql_in_stage.sv =====
// input register stage with its valid/stall handshake
module u8vql_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  u8vql_pkg::item_t item_i,
  input  logic             core_ready_i,
  output logic             item_valid_o,
  output u8vql_pkg::item_t item_o
);
  import u8vql_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  take;

  // stage is free when empty or when its item moves on this cycle
  assign take       = !valid_q || core_ready_i;
  assign in_stall_o = !take;
  assign valid_d    = take ? in_valid_i : valid_q;

  // control register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (take && in_valid_i) begin
      item_q <= item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;
endmodule

// ===== sv/u8vql_core.sv =====
// decode state, quoting counter and result forming for one byte per cycle in which fire_i is set
module u8vql_core #(
  parameter int unsigned LENGTH_WIDTH = u8vql_pkg::LENGTH_WIDTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  u8vql_pkg::item_t   item_i,
  output u8vql_pkg::result_t result_o
);
  import u8vql_pkg::*;

  localparam int unsigned SW = LENGTH_WIDTH + 3;
  localparam logic [LENGTH_WIDTH-1:0] LenMax = '1;

  logic [1:0]              be_q, be_d, be_n;
  cls_e                    cls_q, cls_d, cls_n;
  logic                    pair_q, pair_d, pair_n;
  logic [LENGTH_WIDTH-1:0] run_q, run_d, run_n;
  logic [LENGTH_WIDTH-1:0] bs_q, bs_d, bs_n;
  logic                    err_q, err_d, err_n;
  logic                    sat_q, sat_d, sat_n;

  logic [7:0]    b;
  logic          flush, dbl, ov, over;
  logic [1:0]    units;
  logic [SW-1:0] add, sum;

  assign b = item_i.data_byte;

  // byte decode and pending backslash tracking
  always_comb begin
    be_n   = be_q;
    cls_n  = cls_q;
    pair_n = pair_q;
    bs_n   = bs_q;
    err_n  = err_q;
    flush  = 1'b0;
    dbl    = 1'b0;
    units  = 2'd0;
    if (item_i.has_byte && !err_q) begin
      if (be_q == 2'd0) begin
        if (b == BYTE_BACKSLASH) begin
          if (bs_q != LenMax) begin
            bs_n = bs_q + LENGTH_WIDTH'(1);
          end
        end else if (b == BYTE_QUOTE) begin
          // doubled backslashes, escape and the quote itself
          flush = 1'b1;
          dbl   = 1'b1;
          units = 2'd2;
          bs_n  = '0;
        end else if (b < BYTE_CONT_LO) begin
          flush = 1'b1;
          units = 2'd1;
          bs_n  = '0;
        end else begin
          pair_n = 1'b0;
          cls_n  = CLS_ANY;
          if (b >= BYTE_LEAD2_LO && b <= BYTE_LEAD2_HI) begin
            be_n = 2'd1;
          end else if (b >= BYTE_LEAD3_LO && b <= BYTE_LEAD3_HI) begin
            be_n = 2'd2;
            if (b == BYTE_LEAD3_LO) begin
              cls_n = CLS_E0;
            end else if (b == BYTE_LEAD3_SR) begin
              cls_n = CLS_ED;
            end
          end else if (b >= BYTE_LEAD4_LO && b <= BYTE_LEAD4_HI) begin
            be_n   = 2'd3;
            pair_n = 1'b1;
            if (b == BYTE_LEAD4_LO) begin
              cls_n = CLS_F0;
            end else if (b == BYTE_LEAD4_HI) begin
              cls_n = CLS_F4;
            end
          end else begin
            err_n = 1'b1;
          end
        end
      end else if (!in_class(cls_q, b)) begin
        err_n = 1'b1;
      end else begin
        cls_n = CLS_ANY;
        be_n  = be_q - 2'd1;
        if (be_q == 2'd1) begin
          flush = 1'b1;
          units = pair_q ? 2'd2 : 2'd1;
          bs_n  = '0;
        end
      end
    end
    // truncated sequence at the end of the string
    if (item_i.last && be_n != 2'd0) begin
      err_n = 1'b1;
    end
  end

  // one saturating add covers every length step of this byte and the closing quote
  always_comb begin
    if (err_n) begin
      add = '0;
    end else if (flush) begin
      add = (dbl ? (SW'(bs_q) << 1) : SW'(bs_q)) + SW'(units) + SW'(item_i.last);
    end else if (item_i.last) begin
      add = (SW'(bs_n) << 1) + SW'(1'b1);
    end else begin
      add = '0;
    end
    sum   = SW'(run_q) + add;
    ov    = sum > SW'(LenMax);
    run_n = ov ? LenMax : sum[LENGTH_WIDTH-1:0];
    sat_n = sat_q | ov;
  end

  // count that does not fit the reported width
  if (LENGTH_WIDTH > OUT_LEN_W) begin : g_wide
    assign over = |run_n[LENGTH_WIDTH-1:OUT_LEN_W];
  end else begin : g_narrow
    assign over = 1'b0;
  end

  // result of a string that ends with this item
  always_comb begin
    result_o.utf8_ok          = !err_n;
    result_o.length_saturated = !err_n && sat_n;
    if (err_n) begin
      result_o.quoted_length = '0;
    end else if (sat_n || over) begin
      result_o.quoted_length = '1;
    end else begin
      result_o.quoted_length = OUT_LEN_W'(run_n);
    end
  end

  // next state, back to the start values after the last byte
  always_comb begin
    if (item_i.last) begin
      be_d   = 2'd0;
      cls_d  = CLS_ANY;
      pair_d = 1'b0;
      run_d  = LENGTH_WIDTH'(1);
      bs_d   = '0;
      err_d  = 1'b0;
      sat_d  = 1'b0;
    end else begin
      be_d   = be_n;
      cls_d  = cls_n;
      pair_d = pair_n;
      run_d  = run_n;
      bs_d   = bs_n;
      err_d  = err_n;
      sat_d  = sat_n;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      be_q   <= 2'd0;
      cls_q  <= CLS_ANY;
      pair_q <= 1'b0;
      run_q  <= LENGTH_WIDTH'(1);
      bs_q   <= '0;
      err_q  <= 1'b0;
      sat_q  <= 1'b0;
    end else if (fire_i) begin
      be_q   <= be_d;
      cls_q  <= cls_d;
      pair_q <= pair_d;
      run_q  <= run_d;
      bs_q   <= bs_d;
      err_q  <= err_d;
      sat_q  <= sat_d;
    end
  end
endmodule

// ===== sv/u8vql_out_stage.sv =====
// result register with its valid/stall handshake
module u8vql_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  u8vql_pkg::result_t result_i,
  output logic               can_load_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output u8vql_pkg::result_t result_o
);
  import u8vql_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  // free when empty or when the held result transfers now
  assign can_load_o = !(valid_q && out_stall_i);

  always_comb begin
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_stall_i) begin
      valid_d = valid_q;
    end else begin
      valid_d = 1'b0;
    end
  end

  // control register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;
endmodule

// ===== sv/utf8_validate_quoted_utf16_length.sv =====
// top level of the strict utf-8 validator and quoted utf-16 length counter
//
// The input channel carries one string byte per transfer (data_byte_i,
// has_byte_i, last_i) under in_valid_i / in_stall_o. A string ends on the
// transfer with last_i set; has_byte_i low with last_i high ends it with no
// byte, or is an empty string if no byte came before. Exactly one result per
// string leaves on the output channel (utf8_ok_o, quoted_length_o,
// length_saturated_o) under out_valid_o / out_stall_i.
// Throughput is one byte per cycle unless a last byte waits for the result
// register: bytes pass an input register, the decode and one saturating
// length add, then the result register.
// While the receiver stalls, the held result stays put; further bytes of
// the next string keep flowing, and only a next last byte waits in the
// input register until the result register frees up.
// Reset empties both registers and returns the decode state and counter to
// the start of a string (length one, the opening quote).
module utf8_validate_quoted_utf16_length #(
  parameter int unsigned LENGTH_WIDTH = u8vql_pkg::LENGTH_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        utf8_ok_o,
  output logic [31:0] quoted_length_o,
  output logic        length_saturated_o
);
  import u8vql_pkg::*;

  item_t   in_item, item;
  result_t core_result, out_result;
  logic    item_valid, core_ready, can_load, fire;

  assign in_item.data_byte = data_byte_i;
  assign in_item.has_byte  = has_byte_i;
  assign in_item.last      = last_i;

  // a last byte moves on only when the result register can take its result
  assign core_ready = !item.last || can_load;
  assign fire       = item_valid && core_ready;

  u8vql_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .item_i       (in_item),
    .core_ready_i (core_ready),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  u8vql_core #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (item),
    .result_o (core_result)
  );

  u8vql_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire && item.last),
    .result_i    (core_result),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_result)
  );

  assign utf8_ok_o          = out_result.utf8_ok;
  assign quoted_length_o    = out_result.quoted_length;
  assign length_saturated_o = out_result.length_saturated;
endmodule

// ===== sv/u8vql_checker.sv =====
// port level checks of the validator, bound to the top level
module u8vql_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  data_byte_i,
  input logic        has_byte_i,
  input logic        last_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        utf8_ok_o,
  input logic [31:0] quoted_length_o,
  input logic        length_saturated_o
);

  // a stalled result is held
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // an invalid string reports zero length and no saturation
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !utf8_ok_o |-> quoted_length_o == 32'd0 && !length_saturated_o)
    else $error("invalid string with nonzero length");

  // a valid string holds at least both quotes
  a_ok_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && utf8_ok_o |-> quoted_length_o >= 32'd2)
    else $error("valid string shorter than its quotes");

  // saturation reports all ones
  a_sat_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && length_saturated_o |-> utf8_ok_o && quoted_length_o == 32'hffff_ffff)
    else $error("saturated length not all ones");

endmodule

bind utf8_validate_quoted_utf16_length u8vql_checker u_checker (.*);

// ===== dv/testbench.sv =====
// self-checking testbench for the strict utf-8 validator and quoted utf-16 length counter
module testbench;
  import u8vql_pkg::*;

  localparam int unsigned LW         = LENGTH_WIDTH_DEF;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  data_byte_i;
  logic        has_byte_i;
  logic        last_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        utf8_ok_o;
  logic [31:0] quoted_length_o;
  logic        length_saturated_o;

  utf8_validate_quoted_utf16_length dut (.*);

  // idling and pressure controls
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned noise_pct;
  int unsigned hold_requests;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned items_sent;
  int unsigned fail_count;

  // string decode and length state of the predictor
  logic [1:0]    cont_left;
  cls_e          cont_range;
  logic          needs_pair;
  logic [LW-1:0] utf16_len;
  logic [LW-1:0] pending_backslashes;
  logic          bad_utf8;
  logic          len_saturated;

  result_t    expected_results[$];
  logic [7:0] str_bytes[$];

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic bit chance(input int unsigned pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // receiver stall: long hold-off on request, random stalls otherwise
  always @(posedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= chance(rx_idle_pct);
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("mismatch at cycle %0d: %s expected %0d got %0d", cycle_count, what, want, got);
    fail_count++;
  endtask

  // compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with none pending, quoted_length", 32'd0, quoted_length_o);
      end else begin
        want = expected_results.pop_front();
        if (utf8_ok_o !== want.utf8_ok)
          report_mismatch("utf8_ok", 32'(want.utf8_ok), 32'(utf8_ok_o));
        if (quoted_length_o !== want.quoted_length)
          report_mismatch("quoted_length", want.quoted_length, quoted_length_o);
        if (length_saturated_o !== want.length_saturated)
          report_mismatch("length_saturated", 32'(want.length_saturated),
                          32'(length_saturated_o));
      end
    end
  end

  // predictor: saturating add to the running length
  function automatic void add_units(input logic [LW-1:0] amount);
    logic [LW:0] sum;
    sum = {1'b0, utf16_len} + {1'b0, amount};
    if (sum[LW]) begin
      utf16_len     = '1;
      len_saturated = 1'b1;
    end else begin
      utf16_len = sum[LW-1:0];
    end
  endfunction

  function automatic bit cont_in_range(input cls_e rng, input logic [7:0] b);
    case (rng)
      CLS_E0:  return b >= BYTE_E0_LO && b <= BYTE_CONT_HI;
      CLS_ED:  return b >= BYTE_CONT_LO && b <= BYTE_ED_HI;
      CLS_F0:  return b >= BYTE_F0_LO && b <= BYTE_CONT_HI;
      CLS_F4:  return b >= BYTE_CONT_LO && b <= BYTE_F4_HI;
      default: return b >= BYTE_CONT_LO && b <= BYTE_CONT_HI;
    endcase
  endfunction

  // a finished character releases pending backslashes as they are
  function automatic void close_char(input logic [LW-1:0] units);
    add_units(pending_backslashes);
    add_units(units);
    pending_backslashes = '0;
  endfunction

  function automatic void clear_string_state();
    cont_left           = '0;
    cont_range          = CLS_ANY;
    needs_pair          = 1'b0;
    utf16_len           = LW'(1);
    pending_backslashes = '0;
    bad_utf8            = 1'b0;
    len_saturated       = 1'b0;
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    if (bad_utf8) return;
    if (cont_left != 0) begin
      if (!cont_in_range(cont_range, b)) begin
        bad_utf8 = 1'b1;
        return;
      end
      cont_range = CLS_ANY;
      cont_left  = cont_left - 2'd1;
      if (cont_left == 0) close_char(needs_pair ? 2 : 1);
      return;
    end
    // ascii: backslashes wait, a quote doubles them and gets escaped
    if (!b[7]) begin
      if (b == BYTE_BACKSLASH) begin
        if (pending_backslashes != '1) pending_backslashes++;
      end else if (b == BYTE_QUOTE) begin
        add_units(pending_backslashes);
        add_units(pending_backslashes);
        add_units(2);
        pending_backslashes = '0;
      end else begin
        close_char(1);
      end
      return;
    end
    // lead byte of a multibyte sequence
    needs_pair = 1'b0;
    cont_range = CLS_ANY;
    if (b >= BYTE_LEAD2_LO && b <= BYTE_LEAD2_HI) begin
      cont_left = 2'd1;
    end else if (b >= BYTE_LEAD3_LO && b <= BYTE_LEAD3_HI) begin
      cont_left = 2'd2;
      if (b == BYTE_LEAD3_LO) cont_range = CLS_E0;
      else if (b == BYTE_LEAD3_SR) cont_range = CLS_ED;
    end else if (b >= BYTE_LEAD4_LO && b <= BYTE_LEAD4_HI) begin
      cont_left  = 2'd3;
      needs_pair = 1'b1;
      if (b == BYTE_LEAD4_LO) cont_range = CLS_F0;
      else if (b == BYTE_LEAD4_HI) cont_range = CLS_F4;
    end else begin
      bad_utf8 = 1'b1;
    end
  endfunction

  // closing quote plus doubled trailing backslashes, then the result
  function automatic result_t end_string();
    result_t res;
    if (cont_left != 0) bad_utf8 = 1'b1;
    if (!bad_utf8) begin
      add_units(pending_backslashes);
      add_units(pending_backslashes);
      add_units(1);
    end
    res = '0;
    if (!bad_utf8) begin
      res.utf8_ok          = 1'b1;
      res.quoted_length    = len_saturated ? '1 : utf16_len[31:0];
      res.length_saturated = len_saturated;
    end
    clear_string_state();
    return res;
  endfunction

  // one input transfer, with random idle cycles ahead of it
  task automatic send_item(input logic [7:0] b, input logic hb, input logic lst);
    while (chance(tx_idle_pct)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    has_byte_i  <= hb;
    last_i      <= lst;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (hb) decode_byte(b);
    if (lst) expected_results.push_back(end_string());
    if (hb || lst) items_sent++;
  endtask

  // send str_bytes as one string, optionally ended by a separate empty transfer
  task automatic send_str(input bit split_end);
    int n;
    n = str_bytes.size();
    for (int i = 0; i < n; i++) begin
      if (chance(noise_pct)) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(str_bytes[i], 1'b1, (i == n - 1) && !split_end);
    end
    if (n == 0 || split_end) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // value in [lo, hi], often an end point
  function automatic logic [7:0] pick_byte(input logic [7:0] lo, input logic [7:0] hi);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return 8'($urandom_range(hi, lo));
  endfunction

  // one well-formed character or quoting run
  function automatic void add_good_char();
    int unsigned r;
    logic [7:0]  lead;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      str_bytes.push_back(8'($urandom_range(0, 127)));
    end else if (r < 40) begin
      repeat ($urandom_range(1, 5)) str_bytes.push_back(BYTE_BACKSLASH);
    end else if (r < 48) begin
      str_bytes.push_back(BYTE_QUOTE);
    end else if (r < 60) begin
      str_bytes.push_back(pick_byte(BYTE_LEAD2_LO, BYTE_LEAD2_HI));
      str_bytes.push_back(pick_byte(BYTE_CONT_LO, BYTE_CONT_HI));
    end else if (r < 72) begin
      case ($urandom_range(0, 3))
        0:       lead = BYTE_LEAD3_LO;
        1:       lead = BYTE_LEAD3_SR;
        default: lead = pick_byte(BYTE_LEAD3_LO, BYTE_LEAD3_HI);
      endcase
      str_bytes.push_back(lead);
      if (lead == BYTE_LEAD3_LO) str_bytes.push_back(pick_byte(BYTE_E0_LO, BYTE_CONT_HI));
      else if (lead == BYTE_LEAD3_SR) str_bytes.push_back(pick_byte(BYTE_CONT_LO, BYTE_ED_HI));
      else str_bytes.push_back(pick_byte(BYTE_CONT_LO, BYTE_CONT_HI));
      str_bytes.push_back(pick_byte(BYTE_CONT_LO, BYTE_CONT_HI));
    end else begin
      lead = pick_byte(BYTE_LEAD4_LO, BYTE_LEAD4_HI);
      str_bytes.push_back(lead);
      if (lead == BYTE_LEAD4_LO) str_bytes.push_back(pick_byte(BYTE_F0_LO, BYTE_CONT_HI));
      else if (lead == BYTE_LEAD4_HI) str_bytes.push_back(pick_byte(BYTE_CONT_LO, BYTE_F4_HI));
      else str_bytes.push_back(pick_byte(BYTE_CONT_LO, BYTE_CONT_HI));
      repeat (2) str_bytes.push_back(pick_byte(BYTE_CONT_LO, BYTE_CONT_HI));
    end
  endfunction

  // one malformed sequence
  function automatic void add_bad_char();
    case ($urandom_range(0, 8))
      0: str_bytes.push_back(pick_byte(BYTE_CONT_LO, BYTE_CONT_HI));
      1: str_bytes.push_back(chance(40) ? pick_byte(8'hc0, 8'hc1) : pick_byte(8'hf5, 8'hff));
      2: begin
        str_bytes.push_back(BYTE_LEAD3_LO);
        str_bytes.push_back(pick_byte(BYTE_CONT_LO, 8'h9f));
      end
      3: begin
        str_bytes.push_back(BYTE_LEAD3_SR);
        str_bytes.push_back(pick_byte(8'ha0, BYTE_CONT_HI));
      end
      4: begin
        str_bytes.push_back(BYTE_LEAD4_LO);
        str_bytes.push_back(pick_byte(BYTE_CONT_LO, 8'h8f));
      end
      5: begin
        str_bytes.push_back(BYTE_LEAD4_HI);
        str_bytes.push_back(pick_byte(8'h90, BYTE_CONT_HI));
      end
      6: begin
        str_bytes.push_back(pick_byte(BYTE_LEAD2_LO, BYTE_LEAD2_HI));
        str_bytes.push_back(chance(50) ? 8'($urandom_range(0, 127)) : pick_byte(8'hc0, 8'hff));
      end
      7: begin
        str_bytes.push_back(8'he1);
        str_bytes.push_back(BYTE_CONT_LO);
        str_bytes.push_back(8'($urandom_range(0, 127)));
      end
      default: str_bytes.push_back(8'($urandom));
    endcase
  endfunction

  // multibyte sequence cut off by the end of the string
  function automatic void add_cut_sequence();
    case ($urandom_range(0, 2))
      0: str_bytes.push_back(pick_byte(BYTE_LEAD2_LO, BYTE_LEAD2_HI));
      1: begin
        str_bytes.push_back(8'($urandom_range(8'hec, 8'he1)));
        if (chance(50)) str_bytes.push_back(pick_byte(BYTE_CONT_LO, BYTE_CONT_HI));
      end
      default: begin
        str_bytes.push_back(8'($urandom_range(8'hf3, 8'hf1)));
        repeat ($urandom_range(0, 2)) str_bytes.push_back(pick_byte(BYTE_CONT_LO, BYTE_CONT_HI));
      end
    endcase
  endfunction

  // mostly well-formed strings; some carry a malformed or cut-off sequence
  task automatic send_random_string(input bit may_break);
    bit broken;
    int unsigned n_chars;
    str_bytes.delete();
    broken  = may_break && chance(20);
    n_chars = chance(10) ? $urandom_range(10, 30) : $urandom_range(0, 8);
    for (int i = 0; i < n_chars; i++) begin
      if (broken && chance(12)) add_bad_char();
      else add_good_char();
    end
    if (broken && chance(35)) add_cut_sequence();
    send_str(chance(25));
  endtask

  // empty string, quote escaping, trailing backslashes, ignored empty transfers
  task automatic test_quoting_ascii();
    str_bytes.delete();
    send_str(1'b0);
    str_bytes = '{BYTE_BACKSLASH, BYTE_QUOTE, BYTE_BACKSLASH, BYTE_BACKSLASH};
    send_str(1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h7f, 1'b1, 1'b0);
    send_item(BYTE_BACKSLASH, 1'b1, 1'b0);
    send_item(8'h41, 1'b1, 1'b1);
  endtask

  // lowest three-byte and highest four-byte characters
  task automatic test_multibyte_bounds();
    str_bytes = '{BYTE_LEAD3_LO, BYTE_E0_LO, BYTE_CONT_LO,
                  BYTE_LEAD4_HI, BYTE_F4_HI, BYTE_CONT_HI, BYTE_CONT_HI};
    send_str(1'b0);
  endtask

  // surrogate, overlong, cut-off end, and bytes after the first error
  task automatic test_encoding_errors();
    str_bytes = '{BYTE_LEAD3_SR, 8'ha0};
    send_str(1'b0);
    str_bytes = '{BYTE_LEAD4_LO, 8'h8f};
    send_str(1'b0);
    str_bytes = '{BYTE_LEAD2_LO};
    send_str(1'b0);
    str_bytes = '{BYTE_CONT_LO, 8'hff, 8'h41};
    send_str(1'b0);
  endtask

  // receiver holds off while strings keep coming, so the input backs up
  task automatic test_output_backpressure();
    tx_idle_pct = 0;
    hold_requests <= hold_requests + 1;
    repeat (5) send_random_string(1'b0);
  endtask

  task automatic test_random_strings(input int unsigned tx_pct, input int unsigned rx_pct,
                                     input int unsigned n_items);
    int unsigned stop_at;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    noise_pct   = 5;
    stop_at     = items_sent + n_items;
    while (items_sent < stop_at) send_random_string(1'b1);
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    data_byte_i   = '0;
    has_byte_i    = 1'b0;
    last_i        = 1'b0;
    tx_idle_pct   = 14;
    rx_idle_pct   = 53;
    noise_pct     = 0;
    hold_requests = 0;
    items_sent    = 0;
    fail_count    = 0;
    clear_string_state();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_quoting_ascii();
    test_multibyte_bounds();
    test_encoding_errors();
    test_random_strings(14, 53, 170);
    test_output_backpressure();
    wait_for_results();
    test_random_strings(53, 14, 170);
    wait_for_results();
    test_random_strings(0, 0, 170);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/u8vql_pkg.sv
sv/u8vql_in_stage.sv
sv/u8vql_core.sv
sv/u8vql_out_stage.sv
sv/utf8_validate_quoted_utf16_length.sv
sv/u8vql_checker.sv
dv/testbench.sv
